// ===== hw/rtl/dbsm_pkg.sv =====
// shared types, codes and constants of the door brightness state machine
package dbsm_pkg;

   localparam int WINDOW_SIZE_DEF   = 8;
   localparam int DROP_RATIO_DEF    = 179;
   localparam int WINDOW_SIZE_MAX   = 32;
   localparam int LUMA_W            = 16;
   localparam int FILL_MAX_W        = $clog2(WINDOW_SIZE_MAX + 1);
   localparam int COUNT_W           = 8;
   localparam int CSR_INDEX_W       = 3;

   localparam logic [1:0] MODE_CLOSED  = 2'd0;
   localparam logic [1:0] MODE_OPENING = 2'd1;
   localparam logic [1:0] MODE_OPEN    = 2'd2;
   localparam logic [1:0] MODE_CLOSING = 2'd3;

   localparam logic [2:0] EV_NONE    = 3'd0;
   localparam logic [2:0] EV_OPENED  = 3'd1;
   localparam logic [2:0] EV_GUARD   = 3'd2;
   localparam logic [2:0] EV_RESUMED = 3'd3;
   localparam logic [2:0] EV_CLOSED  = 3'd4;

   localparam logic [CSR_INDEX_W-1:0] CSR_OPENING_CANDIDATE = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_OPEN_LIGHT        = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_OPEN_CONFIRM      = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_CLOSE_CONFIRM     = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_CLOSING_GUARD     = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_CLOSING_DARK      = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_REFERENCE_LUMA    = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] CSR_REFERENCE_DARK    = 3'd7;

   typedef struct packed {
      logic                  push;
      logic                  restart;
      logic                  sort_en;
      logic                  sort_odd;
      logic                  capture;
      logic [LUMA_W-1:0]     value;
      logic [FILL_MAX_W-1:0] fill;
   } win_cmd_type;

   function automatic logic [COUNT_W-1:0] sat_inc8(input logic [COUNT_W-1:0] v);
      sat_inc8 = (v == {COUNT_W{1'b1}}) ? v : v + 1'b1;
   endfunction

endpackage

// ===== hw/rtl/dbsm_cell.sv =====
// one window cell: holds a luma and its age, swaps with a neighbor during sorting
module dbsm_cell
   import dbsm_pkg::*;
#(
   parameter int INDEX = 0,
   parameter int WIN   = WINDOW_SIZE_DEF,
   parameter int AGE_W = 3
) (
   input  logic              clock,
   input  win_cmd_type       cmd,
   input  logic [LUMA_W-1:0] left_value,
   input  logic [AGE_W-1:0]  left_age,
   input  logic [LUMA_W-1:0] right_value,
   input  logic [AGE_W-1:0]  right_age,
   output logic [LUMA_W-1:0] value,
   output logic [AGE_W-1:0]  age
);

   localparam logic [FILL_MAX_W-1:0] POS    = FILL_MAX_W'(INDEX);
   localparam logic [FILL_MAX_W-1:0] NEXT   = FILL_MAX_W'(INDEX + 1);
   localparam logic [FILL_MAX_W-1:0] FULL   = FILL_MAX_W'(WIN);
   localparam logic [AGE_W-1:0]      OLDEST = AGE_W'(WIN - 1);
   localparam logic                  PAR    = 1'(INDEX % 2);
   localparam logic                  LPAR   = 1'((INDEX + 1) % 2);
   localparam logic                  HAS_L  = (INDEX > 0);

   logic [LUMA_W-1:0] value_ff, value_in;
   logic [AGE_W-1:0]  age_ff, age_in;
   logic              pair_r, pair_l, full;

   assign full   = (cmd.fill == FULL);
   assign pair_r = cmd.sort_en && (PAR == cmd.sort_odd) && (NEXT < cmd.fill);
   assign pair_l = cmd.sort_en && (LPAR == cmd.sort_odd) && HAS_L && (POS < cmd.fill);

   always_comb begin
      value_in = value_ff;
      age_in   = age_ff;
      priority if (cmd.restart) begin
         if (POS == '0) begin
            value_in = cmd.value;
            age_in   = '0;
         end
      end else if (cmd.push) begin
         if (full) begin
            if (age_ff == OLDEST) begin
               value_in = cmd.value;
               age_in   = '0;
            end else begin
               age_in = age_ff + 1'b1;
            end
         end else if (POS == cmd.fill) begin
            value_in = cmd.value;
            age_in   = '0;
         end else if (POS < cmd.fill) begin
            age_in = age_ff + 1'b1;
         end
      end else if (pair_r && (value_ff > right_value)) begin
         value_in = right_value;
         age_in   = right_age;
      end else if (pair_l && (left_value > value_ff)) begin
         value_in = left_value;
         age_in   = left_age;
      end else begin
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
      age_ff   <= age_in;
   end

   assign value = value_ff;
   assign age   = age_ff;

endmodule

// ===== hw/rtl/dbsm_window.sv =====
// brightness window: chain of sorting cells and median pick
module dbsm_window
   import dbsm_pkg::*;
#(
   parameter int WIN = WINDOW_SIZE_DEF
) (
   input  logic              clock,
   input  win_cmd_type       cmd,
   output logic [LUMA_W-1:0] median
);

   localparam int AGE_W = (WIN > 1) ? $clog2(WIN) : 1;

   logic [LUMA_W-1:0] vals [WIN];
   logic [AGE_W-1:0]  ages [WIN];
   logic [LUMA_W-1:0] lo_ff, hi_ff, lo_pick, hi_pick;
   logic [FILL_MAX_W-1:0] hi_idx, lo_idx;
   logic [LUMA_W:0]   med_sum;

   for (genvar i = 0; i < WIN; i++) begin : g_cell
      logic [LUMA_W-1:0] lv, rv;
      logic [AGE_W-1:0]  la, ra;
      if (i == 0) begin : g_first
         assign lv = vals[i];
         assign la = ages[i];
      end else begin : g_mid_l
         assign lv = vals[i-1];
         assign la = ages[i-1];
      end
      if (i == WIN - 1) begin : g_last
         assign rv = vals[i];
         assign ra = ages[i];
      end else begin : g_mid_r
         assign rv = vals[i+1];
         assign ra = ages[i+1];
      end
      dbsm_cell #(
         .INDEX (i),
         .WIN   (WIN),
         .AGE_W (AGE_W)
      ) u_cell (
         .clock       (clock),
         .cmd         (cmd),
         .left_value  (lv),
         .left_age    (la),
         .right_value (rv),
         .right_age   (ra),
         .value       (vals[i]),
         .age         (ages[i])
      );
   end

   assign hi_idx = cmd.fill >> 1;
   assign lo_idx = cmd.fill[0] ? hi_idx : hi_idx - 1'b1;

   always_comb begin
      lo_pick = '0;
      hi_pick = '0;
      for (int i = 0; i < WIN; i++) begin
         if (FILL_MAX_W'(i) == hi_idx) hi_pick = hi_pick | vals[i];
         if (FILL_MAX_W'(i) == lo_idx) lo_pick = lo_pick | vals[i];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         lo_ff <= lo_pick;
         hi_ff <= hi_pick;
      end
   end

   // odd count picks the same cell twice
   assign med_sum = {1'b0, lo_ff} + {1'b0, hi_ff};
   assign median  = med_sum[LUMA_W:1];

endmodule

// ===== hw/rtl/door_brightness_state_machine.sv =====
// top level: door state machine, configuration registers and result register
//
// One request per camera frame: req_tdata carries mean luma (U8.8) and dark
// fraction (Q0.16). Each request yields one response with door state,
// detection enable, event code and the open brightness reference.
// Registers are written on the csr channel, which is always ready; write
// them only while no request is in flight.
// A request that does not enter the brightness window passes from the
// done phase into the response register; the next request is taken only
// after that load. A request that enters the window while open runs
// WINDOW_SIZE odd-even rounds through the cell chain, one median capture and
// one reference update before its response is loaded in the done phase.
// A new request is taken while a finished response waits in the output
// register; if the receiver stalls, the next result holds until rsp_tready.
// Reset restores the register defaults, closes the door and clears the
// counts, window fill and reference; window cells need no clearing.
module door_brightness_state_machine
   import dbsm_pkg::*;
#(
   parameter int WINDOW_SIZE   = WINDOW_SIZE_DEF,
   parameter int DROP_RATIO_Q8 = DROP_RATIO_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [31:0]            req_tdata,  // mean_luma[15:0], dark_fraction[31:16]
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [23:0]            rsp_tdata,  // door_status[1:0], run_detection[2],
                                              // door_event[5:3], reference_luma[21:6], zero
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [15:0]            csr_data
);

   localparam int FILL_W  = $clog2(WINDOW_SIZE + 1);
   localparam int ROUND_W = (WINDOW_SIZE > 1) ? $clog2(WINDOW_SIZE) : 1;
   localparam logic [FILL_W-1:0]  FILL_FULL  = FILL_W'(WINDOW_SIZE);
   localparam logic [ROUND_W-1:0] ROUND_LAST = ROUND_W'(WINDOW_SIZE - 1);
   localparam logic [8:0]         DROP       = 9'(DROP_RATIO_Q8);
   localparam int PROD_W = LUMA_W + 9;

   localparam logic [2:0] P_IDLE = 3'd0;
   localparam logic [2:0] P_SORT = 3'd1;
   localparam logic [2:0] P_MED  = 3'd2;
   localparam logic [2:0] P_REF  = 3'd3;
   localparam logic [2:0] P_DONE = 3'd4;

   logic [LUMA_W-1:0]  ocl_ff, oll_ff, cgl_ff, cdf_ff, rul_ff, rdl_ff;
   logic [COUNT_W-1:0] ocf_ff, ccf_ff;

   logic [1:0]         mode_ff, mode_in;
   logic [COUNT_W-1:0] ocnt_ff, ocnt_in, ccnt_ff, ccnt_in, inc_open, inc_close;
   logic [FILL_W-1:0]  fill_ff;
   logic [LUMA_W-1:0]  ref_ff;
   logic [2:0]         phase_ff;
   logic [ROUND_W-1:0] round_ff;
   logic [1:0]         pend_state_ff;
   logic               pend_run_ff;
   logic [2:0]         pend_event_ff;
   logic               rsp_valid_ff;
   logic [23:0]        rsp_data_ff;

   logic [LUMA_W-1:0]  luma, dark, median;
   logic               accept, closing, run_d, push_d, restart_d, load_rsp;
   logic [2:0]         event_d;
   logic [PROD_W-1:0]  drop_prod, luma_scaled;
   win_cmd_type        cmd;

   assign luma       = req_tdata[15:0];
   assign dark       = req_tdata[31:16];
   assign req_tready = (phase_ff == P_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;
   assign load_rsp   = (phase_ff == P_DONE) && (!rsp_valid_ff || rsp_tready);

   assign drop_prod   = {9'd0, ref_ff} * {16'd0, DROP};
   assign luma_scaled = {1'b0, luma, 8'd0};
   assign closing     = (ref_ff != '0) && (luma <= cgl_ff) &&
                        (luma_scaled <= drop_prod) && (dark >= cdf_ff);
   assign inc_open    = sat_inc8(ocnt_ff);
   assign inc_close   = sat_inc8(ccnt_ff);

   always_comb begin
      mode_in   = mode_ff;
      ocnt_in   = ocnt_ff;
      ccnt_in   = ccnt_ff;
      run_d     = 1'b0;
      event_d   = EV_NONE;
      push_d    = 1'b0;
      restart_d = 1'b0;
      unique case (mode_ff)
         MODE_CLOSED: begin
            if (luma >= ocl_ff) begin
               mode_in = MODE_OPENING;
               ocnt_in = 8'd1;
            end
         end
         MODE_OPENING: begin
            if (luma >= oll_ff) begin
               ocnt_in = inc_open;
               if (inc_open >= ocf_ff) begin
                  mode_in   = MODE_OPEN;
                  restart_d = 1'b1;
                  event_d   = EV_OPENED;
               end
            end else begin
               mode_in = MODE_CLOSED;
               ocnt_in = '0;
            end
         end
         MODE_CLOSING: begin
            if (closing) begin
               ccnt_in = inc_close;
               if (inc_close >= ccf_ff) begin
                  mode_in = MODE_CLOSED;
                  ccnt_in = '0;
                  event_d = EV_CLOSED;
               end
            end else begin
               mode_in = MODE_OPEN;
               ccnt_in = '0;
               event_d = EV_RESUMED;
            end
         end
         MODE_OPEN: begin
            if (closing) begin
               mode_in = MODE_CLOSING;
               ccnt_in = 8'd1;
               event_d = EV_GUARD;
            end else begin
               push_d = (luma >= rul_ff) && (dark <= rdl_ff);
               run_d  = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   assign cmd.push     = accept && push_d;
   assign cmd.restart  = accept && restart_d;
   assign cmd.sort_en  = (phase_ff == P_SORT);
   assign cmd.sort_odd = round_ff[0];
   assign cmd.capture  = (phase_ff == P_MED);
   assign cmd.value    = luma;
   assign cmd.fill     = FILL_MAX_W'(fill_ff);

   dbsm_window #(
      .WIN (WINDOW_SIZE)
   ) u_window (
      .clock  (clock),
      .cmd    (cmd),
      .median (median)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         ocl_ff <= 16'd10240;
         oll_ff <= 16'd15360;
         ocf_ff <= 8'd3;
         ccf_ff <= 8'd3;
         cgl_ff <= 16'd7680;
         cdf_ff <= 16'd45875;
         rul_ff <= 16'd15360;
         rdl_ff <= 16'd19661;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_OPENING_CANDIDATE: ocl_ff <= csr_data;
            CSR_OPEN_LIGHT:        oll_ff <= csr_data;
            CSR_OPEN_CONFIRM:      ocf_ff <= csr_data[7:0];
            CSR_CLOSE_CONFIRM:     ccf_ff <= csr_data[7:0];
            CSR_CLOSING_GUARD:     cgl_ff <= csr_data;
            CSR_CLOSING_DARK:      cdf_ff <= csr_data;
            CSR_REFERENCE_LUMA:    rul_ff <= csr_data;
            CSR_REFERENCE_DARK:    rdl_ff <= csr_data;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_CLOSED;
         ocnt_ff      <= '0;
         ccnt_ff      <= '0;
         fill_ff      <= '0;
         ref_ff       <= '0;
         phase_ff     <= P_IDLE;
         round_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (phase_ff)
            P_IDLE: begin
               if (accept) begin
                  mode_ff <= mode_in;
                  ocnt_ff <= ocnt_in;
                  ccnt_ff <= ccnt_in;
                  if (restart_d) begin
                     fill_ff <= FILL_W'(1);
                     ref_ff  <= luma;
                  end else if (push_d && (fill_ff != FILL_FULL)) begin
                     fill_ff <= fill_ff + 1'b1;
                  end
                  phase_ff <= push_d ? P_SORT : P_DONE;
                  round_ff <= '0;
               end
            end
            P_SORT: begin
               if (round_ff == ROUND_LAST) begin
                  phase_ff <= P_MED;
                  round_ff <= '0;
               end else begin
                  round_ff <= round_ff + 1'b1;
               end
            end
            P_MED: phase_ff <= P_REF;
            P_REF: begin
               ref_ff   <= median;
               phase_ff <= P_DONE;
            end
            P_DONE: begin
               if (load_rsp) begin
                  phase_ff <= P_IDLE;
               end
            end
            default: phase_ff <= P_IDLE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         pend_state_ff <= mode_in;
         pend_run_ff   <= run_d;
         pend_event_ff <= event_d;
      end
      if (load_rsp) begin
         rsp_data_ff <= {2'b00, ref_ff, pend_event_ff, pend_run_ff, pend_state_ff};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   a_accept_leaves_idle : assert property (@(posedge clock) disable iff (reset)
      accept |=> (phase_ff != P_IDLE))
      else $error("phase did not advance after a request");

   a_fill_bounded : assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FILL_FULL)
      else $error("window fill beyond window size");

   a_open_has_window : assert property (@(posedge clock) disable iff (reset)
      ((mode_ff == MODE_OPEN) || (mode_ff == MODE_CLOSING)) |-> (fill_ff != '0))
      else $error("door open with empty window");

   a_opened_event_state : assert property (@(posedge clock) disable iff (reset)
      ((phase_ff == P_DONE) && (pend_event_ff == EV_OPENED)) |-> (pend_state_ff == MODE_OPEN))
      else $error("opened event without open state");

endmodule

// ===== verif/tb_door_brightness_state_machine.sv =====
// self-checking testbench for the door brightness state machine with a predicting scoreboard
`timescale 1ns / 100ps

module tb_door_brightness_state_machine;
   import dbsm_pkg::*;

   localparam int QUIET_LIMIT = 4000;
   localparam int SEGMENTS    = 6;

   // directed frames {dark_fraction, mean_luma} under the reset register values
   localparam logic [31:0] OPENING_SCRIPT [24] = '{
      32'h0000_0000, 32'hFFFF_27FF, 32'h0000_2800, 32'h0000_3BFF,
      32'hFFFF_FFFF, 32'h0000_3C00, 32'h0000_FFFF, 32'h4CCD_3C00,
      32'h4CCE_5000, 32'h0000_3BFF, 32'h0000_8001, 32'hB333_1E00,
      32'hB333_1E01, 32'hFFFF_1E00, 32'hFFFF_0000, 32'hB333_0000,
      32'h0000_FFFF, 32'h0000_3C00, 32'h0000_3C00, 32'hB332_1E00,
      32'hB333_1E00, 32'h0000_FFFF, 32'h0000_FFFF, 32'h0000_0001
   };

   typedef struct packed {
      logic [1:0]  state;
      logic        run;
      logic [2:0]  ev;
      logic [15:0] refl;
   } door_result_type;

   class frame_scoreboard;
      logic [15:0]  cand_luma, light_luma, guard_luma, close_dark, upd_luma, upd_dark;
      logic [7:0]   open_need, close_need;
      logic [1:0]   mode;
      logic [7:0]   open_cnt, close_cnt;
      logic [15:0]  win [WINDOW_SIZE_DEF];
      int           fill, oldest;
      logic [15:0]  refl;
      door_result_type expected_results [$];
      int           errors, checked, frames, opened, closed, window_updates;

      function new();
         cand_luma  = 16'd10240;
         light_luma = 16'd15360;
         open_need  = 8'd3;
         close_need = 8'd3;
         guard_luma = 16'd7680;
         close_dark = 16'd45875;
         upd_luma   = 16'd15360;
         upd_dark   = 16'd19661;
         mode       = MODE_CLOSED;
         open_cnt   = '0;
         close_cnt  = '0;
         fill       = 0;
         oldest     = 0;
         refl       = '0;
      endfunction

      function void write_reg(logic [CSR_INDEX_W-1:0] idx, logic [15:0] val);
         case (idx)
            CSR_OPENING_CANDIDATE: cand_luma  = val;
            CSR_OPEN_LIGHT:        light_luma = val;
            CSR_OPEN_CONFIRM:      open_need  = val[7:0];
            CSR_CLOSE_CONFIRM:     close_need = val[7:0];
            CSR_CLOSING_GUARD:     guard_luma = val;
            CSR_CLOSING_DARK:      close_dark = val;
            CSR_REFERENCE_LUMA:    upd_luma   = val;
            CSR_REFERENCE_DARK:    upd_dark   = val;
            default: ;
         endcase
      endfunction

      function logic [7:0] saturate_up(logic [7:0] v);
         return (v == 8'hFF) ? v : v + 8'd1;
      endfunction

      function void window_push(logic [15:0] luma);
         if (fill < WINDOW_SIZE_DEF) begin
            win[(oldest + fill) % WINDOW_SIZE_DEF] = luma;
            fill++;
         end else begin
            win[oldest] = luma;
            oldest = (oldest + 1) % WINDOW_SIZE_DEF;
         end
      endfunction

      function logic [15:0] window_median();
         logic [15:0] sorted [WINDOW_SIZE_DEF];
         logic [15:0] key;
         int i, j;
         for (i = 0; i < fill; i++) sorted[i] = win[(oldest + i) % WINDOW_SIZE_DEF];
         for (i = 1; i < fill; i++) begin
            key = sorted[i];
            j = i;
            while (j > 0 && sorted[j-1] > key) begin
               sorted[j] = sorted[j-1];
               j--;
            end
            sorted[j] = key;
         end
         if (fill % 2) return sorted[fill/2];
         return 16'((17'(sorted[fill/2-1]) + 17'(sorted[fill/2])) >> 1);
      endfunction

      function void note_frame(logic [15:0] luma, logic [15:0] dark);
         door_result_type r;
         logic         closing;
         closing = (refl != 16'd0) && (luma <= guard_luma) &&
                   ((32'(luma) << 8) <= 32'(refl) * 32'(DROP_RATIO_DEF)) &&
                   (dark >= close_dark);
         r.run = 1'b0;
         r.ev  = EV_NONE;
         case (mode)
            MODE_CLOSED: begin
               if (luma >= cand_luma) begin
                  mode = MODE_OPENING;
                  open_cnt = 8'd1;
               end
            end
            MODE_OPENING: begin
               if (luma >= light_luma) begin
                  open_cnt = saturate_up(open_cnt);
                  if (open_cnt >= open_need) begin
                     mode = MODE_OPEN;
                     fill = 0;
                     oldest = 0;
                     window_push(luma);
                     refl = luma;
                     r.ev = EV_OPENED;
                     opened++;
                  end
               end else begin
                  mode = MODE_CLOSED;
                  open_cnt = '0;
               end
            end
            MODE_CLOSING: begin
               if (closing) begin
                  close_cnt = saturate_up(close_cnt);
                  if (close_cnt >= close_need) begin
                     mode = MODE_CLOSED;
                     close_cnt = '0;
                     r.ev = EV_CLOSED;
                     closed++;
                  end
               end else begin
                  mode = MODE_OPEN;
                  close_cnt = '0;
                  r.ev = EV_RESUMED;
               end
            end
            default: begin
               if (closing) begin
                  mode = MODE_CLOSING;
                  close_cnt = 8'd1;
                  r.ev = EV_GUARD;
               end else begin
                  if (luma >= upd_luma && dark <= upd_dark) begin
                     window_push(luma);
                     refl = window_median();
                     window_updates++;
                  end
                  r.run = 1'b1;
               end
            end
         endcase
         r.state = mode;
         r.refl  = refl;
         expected_results = {expected_results, r};
         frames++;
      endfunction

      task report(string what);
         errors++;
         $display("%0t response %0d: %s", $time, checked, what);
      endtask

      task check_result(door_result_type got);
         door_result_type want;
         if (expected_results.size() == 0) begin
            report($sformatf("unexpected response %h", got));
            return;
         end
         want = expected_results[0];
         expected_results.delete(0);
         checked++;
         if (got.state !== want.state)
            report($sformatf("state %0d, expected %0d", got.state, want.state));
         if (got.run !== want.run)
            report($sformatf("run_detection %0d, expected %0d", got.run, want.run));
         if (got.ev !== want.ev)
            report($sformatf("door_event %0d, expected %0d", got.ev, want.ev));
         if (got.refl !== want.refl)
            report($sformatf("reference_luma %h, expected %h", got.refl, want.refl));
      endtask
   endclass

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [31:0]            req_tdata  = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [23:0]            rsp_tdata;
   logic                   csr_valid  = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index  = CSR_OPENING_CANDIDATE;
   logic [15:0]            csr_data   = '0;

   frame_scoreboard sb;
   int              send_idle_pct = 0;
   int              recv_idle_pct = 0;
   int              quiet_cycles  = 0;
   int              settings_used = 1;

   door_brightness_state_machine u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #1 clock = ~clock;

   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         sb.check_result(door_result_type'({rsp_tdata[1:0], rsp_tdata[2], rsp_tdata[5:3],
                                            rsp_tdata[21:6]}));
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("tb_door_brightness_state_machine: done, errors");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   function automatic int span(int lo, int hi);
      return (hi <= lo) ? lo : lo + $urandom_range(0, hi - lo);
   endfunction

   task automatic closing_pick(output logic [15:0] luma, output logic [15:0] dark);
      int lim;
      lim = int'(sb.guard_luma);
      if (((int'(sb.refl) * DROP_RATIO_DEF) >> 8) < lim) lim = (int'(sb.refl) * DROP_RATIO_DEF) >> 8;
      luma = 16'(span(0, lim));
      dark = 16'(span(int'(sb.close_dark), 16'hFFFF));
   endtask

   // mostly frames that move the door along its cycle, some noise
   task automatic pick_frame(output logic [15:0] luma, output logic [15:0] dark);
      int roll;
      roll = $urandom_range(0, 99);
      if ((sb.mode == MODE_OPENING && sb.open_need > 8'd16) ||
          (sb.mode == MODE_CLOSING && sb.close_need > 8'd16))
         roll = 50;
      luma = 16'($urandom);
      dark = 16'($urandom);
      if (roll < 6) begin
         luma = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
         dark = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
      end else if (roll >= 18) begin
         case (sb.mode)
            MODE_CLOSED: begin
               if (roll < 85) luma = 16'(span(int'(sb.cand_luma), 16'hFFFF));
               else luma = 16'(span(0, int'(sb.cand_luma)));
            end
            MODE_OPENING: luma = 16'(span(int'(sb.light_luma), 16'hFFFF));
            MODE_CLOSING: begin
               if (sb.refl != 16'd0) closing_pick(luma, dark);
            end
            default: begin
               if (roll < 90) begin
                  luma = 16'(span(int'(sb.upd_luma), 16'hFFFF));
                  dark = 16'(span(0, int'(sb.upd_dark)));
               end else if (sb.refl != 16'd0) begin
                  closing_pick(luma, dark);
               end
            end
         endcase
      end
   endtask

   task automatic send_frame(input logic [15:0] luma, input logic [15:0] dark);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {dark, luma};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_frame(luma, dark);
      @(negedge clock);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] idx, input logic [15:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      sb.write_reg(idx, val);
      @(negedge clock);
   endtask

   task automatic write_setting(input logic [15:0] cand, input logic [15:0] light,
                                input logic [15:0] open_need, input logic [15:0] close_need,
                                input logic [15:0] guard, input logic [15:0] cdark,
                                input logic [15:0] upd, input logic [15:0] udark);
      write_csr(CSR_OPENING_CANDIDATE, cand);
      write_csr(CSR_OPEN_LIGHT, light);
      write_csr(CSR_OPEN_CONFIRM, open_need);
      write_csr(CSR_CLOSE_CONFIRM, close_need);
      write_csr(CSR_CLOSING_GUARD, guard);
      write_csr(CSR_CLOSING_DARK, cdark);
      write_csr(CSR_REFERENCE_LUMA, upd);
      write_csr(CSR_REFERENCE_DARK, udark);
      csr_valid <= 1'b0;
      settings_used++;
   endtask

   initial begin
      logic [15:0] luma, dark;
      int          seg, budget;
      sb = new();
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      for (seg = 0; seg < SEGMENTS; seg++) begin
         if (seg < 2) begin
            send_idle_pct = 28;
            recv_idle_pct = 59;
         end else if (seg < 4) begin
            send_idle_pct = 59;
            recv_idle_pct = 28;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         case (seg)
            0: begin
               budget = 150;
               foreach (OPENING_SCRIPT[i])
                  send_frame(OPENING_SCRIPT[i][15:0], OPENING_SCRIPT[i][31:16]);
            end
            1: begin
               // lowest thresholds: a zero-luma opening leaves a zero reference
               budget = 120;
               write_setting(16'h0000, 16'h0000, 16'h0001, 16'h0001,
                             16'hFFFF, 16'h0000, 16'h0000, 16'hFFFF);
               repeat (4) send_frame(16'h0000, 16'h0000);
            end
            2: begin
               budget = 130;
               write_setting(16'hFFFF, 16'hFFFF, 16'h0001, 16'h0002,
                             16'h0000, 16'hFFFF, 16'hFFFF, 16'h0000);
            end
            3: begin
               // full-length confirmation in both directions
               budget = 560;
               write_setting(16'h2000, 16'h3000, 16'h00FF, 16'h00FF,
                             16'h2400, 16'hA000, 16'h3000, 16'h6000);
            end
            4: begin
               // zero confirm counts, upper byte of a count register dropped
               budget = 140;
               write_setting(16'($urandom_range(0, 16'h4000)),
                             16'($urandom_range(16'h2000, 16'h6000)),
                             16'h0000, 16'hFF00,
                             16'($urandom_range(16'h1000, 16'h3000)),
                             16'($urandom_range(16'h8000, 16'hFFFF)),
                             16'($urandom_range(16'h2000, 16'h8000)),
                             16'($urandom_range(16'h2000, 16'h8000)));
            end
            default: begin
               budget = 200;
               write_setting(16'($urandom), 16'($urandom),
                             {8'($urandom), 8'($urandom_range(1, 6))},
                             {8'($urandom), 8'($urandom_range(1, 6))},
                             16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
            end
         endcase
         repeat (budget) begin
            pick_frame(luma, dark);
            send_frame(luma, dark);
         end
         req_tvalid <= 1'b0;
         while (sb.expected_results.size() != 0) @(negedge clock);
      end
      repeat (20) @(negedge clock);
      $display("%0d frames over %0d register settings, %0d responses compared",
               sb.frames, settings_used, sb.checked);
      $display("door opened %0d and closed %0d times, %0d reference window updates",
               sb.opened, sb.closed, sb.window_updates);
      if (sb.errors == 0) begin
         $display("tb_door_brightness_state_machine: done, clean");
      end else begin
         $display("tb_door_brightness_state_machine: done, errors");
      end
      $finish;
   end

endmodule
